// ===== hdl/pqaf_pkg.sv =====
// pqaf_pkg: shared types, constants and register indexes for the presence
// qualifier with anti-flicker guard
// no dependencies
package pqaf_pkg;

    localparam int TOGGLE_SLOTS = 4;
    localparam int WINDOW_MS    = 1000;

    localparam int HITS_W  = 8;
    localparam int TIME_W  = 32;
    localparam int RUN_W   = 16;
    localparam int LIMIT_W = 3;
    localparam int CNT_W   = $clog2(TOGGLE_SLOTS + 1);
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    localparam logic [RUN_W-1:0]  RUN_MAX    = {RUN_W{1'b1}};
    localparam logic [TIME_W-1:0] WINDOW_LEN = TIME_W'(WINDOW_MS);

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_A_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZONE_B_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RISE_FRAMES   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_FRAMES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FLICKER_GUARD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STABLE_MS     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TOGGLE_LIMIT  = 3'd7;

    typedef struct packed {
        logic               block_enable;
        logic               zone_a_enable;
        logic               zone_b_enable;
        logic [RUN_W-1:0]   rise_frames;
        logic [RUN_W-1:0]   fall_frames;
        logic               flicker_guard;
        logic [RUN_W-1:0]   stable_ms;
        logic [LIMIT_W-1:0] toggle_limit;
    } pqaf_cfg_t;

    typedef struct packed {
        logic present;
        logic changed;
        logic blocked;
    } pqaf_zone_res_t;

endpackage

// ===== hdl/pqaf_cfg.sv =====
// pqaf_cfg: configuration register file, written through its own port
// depends on pqaf_pkg
module pqaf_cfg
    import pqaf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output pqaf_cfg_t             cfg
);

    pqaf_cfg_t cfg_reg;
    pqaf_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BLOCK_ENABLE:  cfg_next.block_enable  = cfg_data[0];
                REG_ZONE_A_ENABLE: cfg_next.zone_a_enable = cfg_data[0];
                REG_ZONE_B_ENABLE: cfg_next.zone_b_enable = cfg_data[0];
                REG_RISE_FRAMES:   cfg_next.rise_frames   = cfg_data[RUN_W-1:0];
                REG_FALL_FRAMES:   cfg_next.fall_frames   = cfg_data[RUN_W-1:0];
                REG_FLICKER_GUARD: cfg_next.flicker_guard = cfg_data[0];
                REG_STABLE_MS:     cfg_next.stable_ms     = cfg_data[RUN_W-1:0];
                REG_TOGGLE_LIMIT:  cfg_next.toggle_limit  = cfg_data[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_enable  <= 1'b0;
            cfg_reg.zone_a_enable <= 1'b0;
            cfg_reg.zone_b_enable <= 1'b0;
            cfg_reg.rise_frames   <= RUN_W'(3);
            cfg_reg.fall_frames   <= RUN_W'(3);
            cfg_reg.flicker_guard <= 1'b0;
            cfg_reg.stable_ms     <= RUN_W'(200);
            cfg_reg.toggle_limit  <= LIMIT_W'(3);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/pqaf_zone.sv =====
// pqaf_zone: per-zone presence debounce with stable-time and toggle-rate guard
// depends on pqaf_pkg
module pqaf_zone
    import pqaf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              occupied,
    input  logic [TIME_W-1:0] now,
    input  pqaf_cfg_t         cfg,
    output pqaf_zone_res_t    res
);

    logic                    present_reg,  present_next;
    logic [RUN_W-1:0]        occ_run_reg,  occ_run_next;
    logic [RUN_W-1:0]        emp_run_reg,  emp_run_next;
    logic [TIME_W-1:0]       last_chg_reg, last_chg_next;
    logic [TOGGLE_SLOTS-1:0] slot_valid_reg, slot_valid_next;
    logic [TIME_W-1:0]       stamp_reg [TOGGLE_SLOTS];

    logic [RUN_W-1:0]        occ_inc;
    logic [RUN_W-1:0]        emp_inc;
    logic                    due;
    logic                    stable_ok;
    logic [TIME_W-1:0]       since_last;
    logic [TOGGLE_SLOTS-1:0] kept;
    logic [TOGGLE_SLOTS-1:0] free_pick;
    logic [CNT_W-1:0]        kept_cnt;
    logic                    count_ok;
    logic                    allow;
    logic                    accept;
    logic                    refuse;
    logic                    found;

    assign occ_inc = (occ_run_reg == RUN_MAX) ? occ_run_reg : occ_run_reg + 1'b1;
    assign emp_inc = (emp_run_reg == RUN_MAX) ? emp_run_reg : emp_run_reg + 1'b1;

    assign due = occupied ? (!present_reg && (occ_inc >= cfg.rise_frames))
                          : (present_reg && (emp_inc >= cfg.fall_frames));

    assign since_last = now - last_chg_reg;
    assign stable_ok  = since_last >= TIME_W'(cfg.stable_ms);

    // drop stamps that have left the window
    always_comb
    begin
        for (int i = 0; i < TOGGLE_SLOTS; i++)
        begin
            kept[i] = slot_valid_reg[i] && ((now - stamp_reg[i]) < WINDOW_LEN);
        end
    end

    always_comb
    begin
        kept_cnt = '0;
        for (int i = 0; i < TOGGLE_SLOTS; i++)
        begin
            kept_cnt = kept_cnt + CNT_W'(kept[i]);
        end
    end

    assign count_ok = (CMP_W'(kept_cnt) < CMP_W'(cfg.toggle_limit))
                   && (CMP_W'(kept_cnt) < CMP_W'(TOGGLE_SLOTS));
    assign allow  = stable_ok && count_ok;
    assign accept = step && due && (!cfg.flicker_guard || allow);
    assign refuse = step && due && cfg.flicker_guard && !allow;

    // lowest free slot takes the new stamp
    always_comb
    begin
        found     = 1'b0;
        free_pick = '0;
        for (int i = 0; i < TOGGLE_SLOTS; i++)
        begin
            if (!kept[i] && !found)
            begin
                free_pick[i] = 1'b1;
                found        = 1'b1;
            end
        end
    end

    always_comb
    begin
        present_next    = present_reg;
        occ_run_next    = occ_run_reg;
        emp_run_next    = emp_run_reg;
        last_chg_next   = last_chg_reg;
        slot_valid_next = slot_valid_reg;
        if (step)
        begin
            if (occupied)
            begin
                emp_run_next = '0;
                occ_run_next = accept ? '0 : occ_inc;
            end
            else
            begin
                occ_run_next = '0;
                emp_run_next = accept ? '0 : emp_inc;
            end
            if (accept)
            begin
                present_next = !present_reg;
            end
            if (due && cfg.flicker_guard && stable_ok)
            begin
                slot_valid_next = kept;
                if (count_ok)
                begin
                    last_chg_next   = now;
                    slot_valid_next = kept | free_pick;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg    <= 1'b0;
            occ_run_reg    <= '0;
            emp_run_reg    <= '0;
            last_chg_reg   <= '0;
            slot_valid_reg <= '0;
        end
        else
        begin
            present_reg    <= present_next;
            occ_run_reg    <= occ_run_next;
            emp_run_reg    <= emp_run_next;
            last_chg_reg   <= last_chg_next;
            slot_valid_reg <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOGGLE_SLOTS; i++)
        begin
            if (accept && cfg.flicker_guard && free_pick[i])
            begin
                stamp_reg[i] <= now;
            end
        end
    end

    assign res.present = present_next;
    assign res.changed = accept;
    assign res.blocked = refuse;

endmodule

// ===== hdl/presence_qualifier_antiflicker_unit.sv =====
// presence_qualifier_antiflicker_unit: top level, input register, two zone
// qualifiers and result register; depends on pqaf_pkg, pqaf_cfg, pqaf_zone
//
// One frame item is taken per clock cycle, without gaps, as long as results
// are drained. An item lands in the input register, is evaluated against the
// per-zone state once the output register can take it (state is updated at
// that same edge, so the next item sees it at once) and its result is held in
// the output register. The input side keeps accepting while a result waits,
// until both registers are full. Configuration writes are taken in any cycle
// and should be made only while no frame is in flight.
module presence_qualifier_antiflicker_unit
    import pqaf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // zone_a_hits[7:0], zone_b_hits[15:8], time_ms[47:16]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // zone_a_present, zone_a_changed, zone_a_blocked, zone_b_present,
    // zone_b_changed, zone_b_blocked, two zero bits
    output logic [OUT_DATA_W-1:0] m_tdata
);

    pqaf_cfg_t       cfg;
    logic            in_valid_reg;
    logic [IN_DATA_W-1:0] in_data_reg;
    logic            out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic            fire;
    logic            step_a;
    logic            step_b;
    logic [TIME_W-1:0] now;
    pqaf_zone_res_t  res_a;
    pqaf_zone_res_t  res_b;

    pqaf_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign now      = in_data_reg[47:16];
    assign step_a   = fire && cfg.block_enable && cfg.zone_a_enable;
    assign step_b   = fire && cfg.block_enable && cfg.zone_b_enable;

    pqaf_zone u_zone_a
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step_a),
        .occupied (in_data_reg[7:0] != '0),
        .now      (now),
        .cfg      (cfg),
        .res      (res_a)
    );

    pqaf_zone u_zone_b
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step_b),
        .occupied (in_data_reg[15:8] != '0),
        .now      (now),
        .cfg      (cfg),
        .res      (res_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
        if (fire)
        begin
            out_data_reg <= {2'b00,
                             res_b.blocked, res_b.changed, res_b.present,
                             res_a.blocked, res_a.changed, res_a.present};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
